FILE: src/nlms_adaptive_fir_assert.svh
// assertion macros for the nlms adaptive fir
`ifndef NLMS_ADAPTIVE_FIR_ASSERT_SVH
`define NLMS_ADAPTIVE_FIR_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define NLMS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// condition that implies another in the next cycle
`define NLMS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: src/nlms_pkg.sv
`default_nettype none
package nlms_pkg;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 24;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int ACC_W    = 48;
    localparam int DIV_STEPS = 46;

    localparam logic [1:0] ACT_FILT = 2'd0;
    localparam logic [1:0] ACT_UPD  = 2'd1;
    localparam logic [1:0] ACT_CLRH = 2'd2;
    localparam logic [1:0] ACT_CLRC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG  = 8'd1;

    localparam logic [CFG_W-1:0] STEP_RESET = 16'd6554;
    localparam logic [CFG_W-1:0] REG_RESET  = 16'd1;
endpackage
`default_nettype wire

FILE: src/nlms_if.sv
`default_nettype none
interface nlms_in_if import nlms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] error_in;
    modport source (output valid, action, sample_in, error_in, input ready);
    modport sink   (input valid, action, sample_in, error_in, output ready);
endinterface

interface nlms_out_if import nlms_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filter_out;
    modport source (output valid, filter_out, input ready);
    modport sink   (input valid, filter_out, output ready);
endinterface

interface nlms_cfg_if import nlms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/nlms_adaptive_fir.sv
// channel  dir  payload                              handshake
// i_in     in   action, sample_in, error_in          valid/ready
// o_out    out  filter_out                           valid/ready
// i_cfg    in   index, data (step_size, regularizer) valid/ready
//
// one item at a time; a filter item is one multiplier walk over the taps
// an update item is an energy walk, a 46 step divider,
// then a coefficient read-modify-write walk; clear items are done as they are taken
// reset: synchronous active low, history and coefficients cleared through valid bits
// a result waits in the output register; the next item is taken meanwhile
`default_nettype none
`include "nlms_adaptive_fir_assert.svh"
module nlms_adaptive_fir import nlms_pkg::*; #(
    parameter int TAPS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    nlms_in_if.sink    i_in,
    nlms_out_if.source o_out,
    nlms_cfg_if.sink   i_cfg
);
    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1);
    localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
    localparam int DCW = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_OUT} t_state;
    typedef enum logic [1:0] {M_FILT, M_ENER, M_UPD} t_mode;

    t_state r_state;
    t_mode  r_mode;

    logic signed [SAMPLE_W-1:0] r_hist_mem [TAPS];
    logic signed [COEF_W-1:0]   r_coef_mem [TAPS];
    logic [TAPS-1:0] r_hval, r_cval;

    logic [AW-1:0] r_pos, r_ha;
    logic [CW-1:0] r_cnt;
    logic [CFG_W-1:0] r_step, r_reg;
    logic signed [SAMPLE_W-1:0] r_err, r_od;
    logic r_ov;
    logic signed [ACC_W-1:0] r_acc;
    logic [39:0] r_rem;
    logic [45:0] r_quo;
    logic [38:0] r_den;
    logic [DCW-1:0] r_dcnt;
    logic [31:0] r_nu;

    logic r_v1, r_v2, r_v3;
    logic signed [SAMPLE_W-1:0] r_hq;
    logic signed [COEF_W-1:0]   r_cq, r_c2, r_c3;
    logic r_hv1, r_cv1;
    logic [AW-1:0] r_i1, r_i2, r_i3;
    logic signed [39:0] r_m2;
    logic signed [63:0] r_m3;

    logic w_in_fire, w_cfg_fire, w_issue, w_drained;
    logic signed [SAMPLE_W-1:0] w_s;
    logic signed [COEF_W-1:0]   w_c, w_b, w_cnew;
    logic signed [64:0] w_m3;
    logic signed [63:0] w_m3r;
    logic signed [38:0] w_csum;
    logic signed [ACC_W-1:0] w_t;
    logic signed [27:0] w_ys;
    logic signed [SAMPLE_W-1:0] w_y;
    logic [39:0] w_rs;
    logic w_qb;
    logic [45:0] w_qf;
    logic [31:0] w_nu;

    function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign w_issue    = (r_state == S_RUN) && (r_cnt < CW'(TAPS));
    assign w_drained  = !r_v1 && !r_v2 && !r_v3;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.filter_out = r_od;

    assign w_s = r_hv1 ? r_hq : '0;
    assign w_c = r_cv1 ? r_cq : '0;

    always_comb begin
        case (r_mode)
            M_FILT:  w_b = w_c;
            M_ENER:  w_b = COEF_W'(w_s);
            default: w_b = COEF_W'(r_err);
        endcase
    end

    assign w_m3   = $signed(r_m2[31:0]) * $signed({1'b0, r_nu});
    assign w_m3r  = r_m3 + 64'sd33554432;
    assign w_csum = {{15{r_c3[COEF_W-1]}}, r_c3} + {w_m3r[63], w_m3r[63:26]};

    always_comb begin
        if (w_csum > 39'sd8388607) begin
            w_cnew = 24'sh7fffff;
        end else if (w_csum < -39'sd8388608) begin
            w_cnew = 24'sh800000;
        end else begin
            w_cnew = w_csum[COEF_W-1:0];
        end
    end

    assign w_t  = r_acc + 48'sd524288;
    assign w_ys = w_t[47:20];

    always_comb begin
        if (w_ys > 28'sd32767) begin
            w_y = 16'sh7fff;
        end else if (w_ys < -28'sd32768) begin
            w_y = 16'sh8000;
        end else begin
            w_y = w_ys[SAMPLE_W-1:0];
        end
    end

    // restoring divider, one quotient bit a cycle
    assign w_rs = {r_rem[38:0], r_quo[45]};
    assign w_qb = (w_rs >= {1'b0, r_den});
    assign w_qf = {r_quo[44:0], w_qb};
    assign w_nu = (|w_qf[45:32]) ? 32'hffff_ffff : w_qf[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_FILT;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_step  <= STEP_RESET;
            r_reg   <= REG_RESET;
            r_hval  <= '0;
            r_cval  <= '0;
            r_dcnt  <= '0;
        end else begin
            if (w_cfg_fire) begin
                case (i_cfg.index)
                    CFG_STEP: r_step <= i_cfg.data;
                    CFG_REG:  r_reg  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            if (r_v2 && (r_mode != M_UPD)) begin
                r_acc <= r_acc + {{(ACC_W-40){r_m2[39]}}, r_m2};
            end
            if (r_v3) begin
                r_cval[r_i3] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_cnt <= '0;
                        r_acc <= '0;
                        case (i_in.action)
                            ACT_FILT: begin
                                r_hval[r_pos] <= 1'b1;
                                r_mode  <= M_FILT;
                                r_ha    <= r_pos;
                                r_state <= S_RUN;
                            end
                            ACT_UPD: begin
                                r_mode  <= M_ENER;
                                r_ha    <= dec_idx(r_pos);
                                r_err   <= i_in.error_in;
                                r_state <= S_RUN;
                            end
                            ACT_CLRH: begin
                                r_hval <= '0;
                                r_pos  <= '0;
                            end
                            default: begin
                                r_cval <= '0;
                                r_pos  <= '0;
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_issue) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_ha  <= dec_idx(r_ha);
                    end else if (w_drained) begin
                        case (r_mode)
                            M_FILT: r_state <= S_OUT;
                            M_ENER: begin
                                r_rem   <= '0;
                                r_quo   <= {r_step, 30'b0};
                                r_den   <= {23'b0, r_reg} + r_acc[38:0];
                                r_dcnt  <= '0;
                                r_state <= S_DIV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= w_qb ? (w_rs - {1'b0, r_den}) : w_rs;
                    r_quo  <= w_qf;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(DIV_STEPS - 1)) begin
                        r_nu    <= w_nu;
                        r_mode  <= M_UPD;
                        r_cnt   <= '0;
                        r_ha    <= dec_idx(r_pos);
                        r_state <= S_RUN;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_od    <= w_y;
                        r_pos   <= (r_pos == LAST) ? '0 : r_pos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_hq <= r_hist_mem[r_ha];
        r_cq <= r_coef_mem[r_cnt[AW-1:0]];
        if (w_in_fire && (i_in.action == ACT_FILT)) begin
            r_hist_mem[r_pos] <= i_in.sample_in;
        end
        if (r_v3) begin
            r_coef_mem[r_i3] <= w_cnew;
        end
    end

    // pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && (r_mode == M_UPD);
        end
    end

    always_ff @(posedge i_clk) begin
        r_hv1 <= r_hval[r_ha];
        r_cv1 <= r_cval[r_cnt[AW-1:0]];
        r_i1  <= r_cnt[AW-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_m2  <= w_s * w_b;
        r_c2  <= w_c;
        r_c3  <= r_c2;
        r_m3  <= w_m3[63:0];
    end

    `NLMS_ASSERT(a_idle_drained, !i_in.ready || w_drained, "input taken with taps in flight")
    `NLMS_ASSERT(a_cnt_range, r_cnt <= CW'(TAPS), "tap counter out of range")
    `NLMS_ASSERT_NEXT(a_wr_upd, r_v2 && (r_mode == M_UPD), r_v3,
        "coefficient write lost")
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import nlms_pkg::*;

    localparam int NTAPS = 32;

    typedef struct {
        logic [1:0]         action;
        logic signed [15:0] sample;
        logic signed [15:0] err;
        bit                 has_out;
        logic signed [15:0] out_val;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    nlms_in_if  in_ch ();
    nlms_out_if out_ch ();
    nlms_cfg_if cfg_ch ();

    nlms_adaptive_fir #(.TAPS(NTAPS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor state
    logic signed [15:0] hist [NTAPS];
    logic signed [23:0] coef [NTAPS];
    int unsigned        wpos;
    logic [15:0]        mu;
    logic [15:0]        eps;

    logic signed [15:0] filter_q [$];
    int errors;
    int out_seen;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("** nlms_adaptive_fir: FAILED **");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] filter_predict(input logic signed [15:0] s);
        longint acc;
        longint y;
        int unsigned p;
        acc = 0;
        p = wpos;
        hist[p] = s;
        for (int i = 0; i < NTAPS; i++)
            acc += longint'(hist[(p + NTAPS - i) % NTAPS]) * longint'(coef[i]);
        y = floor_sh(acc + (64'sd1 <<< 19), 20);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        wpos = (p + 1 >= NTAPS) ? 0 : p + 1;
        return y[15:0];
    endfunction

    function automatic void adapt_coefs(input logic signed [15:0] e);
        longint unsigned energy;
        longint unsigned denom;
        longint unsigned nu;
        longint sm;
        longint pr;
        longint d;
        longint c;
        energy = 0;
        for (int k = 0; k < NTAPS; k++)
            energy += longint'(hist[k]) * longint'(hist[k]);
        denom = longint'(eps) + energy;
        if (denom == 0) nu = 64'hFFFF_FFFF;
        else begin
            nu = (longint'(mu) << 30) / denom;
            if (nu > 64'hFFFF_FFFF) nu = 64'hFFFF_FFFF;
        end
        for (int i = 0; i < NTAPS; i++) begin
            sm = hist[(wpos + NTAPS - ((i + 1) % NTAPS)) % NTAPS];
            pr = sm * longint'(e) * longint'(nu);
            d = floor_sh(pr + (64'sd1 <<< 25), 26);
            c = longint'(coef[i]) + d;
            if (c > 8388607) c = 8388607;
            if (c < -8388608) c = -8388608;
            coef[i] = c[23:0];
        end
    endfunction

    function automatic void model_item(input logic [1:0] a, input logic signed [15:0] s,
                                       input logic signed [15:0] e);
        case (a)
            ACT_FILT: filter_q.push_back(filter_predict(s));
            ACT_UPD:  adapt_coefs(e);
            ACT_CLRH: begin
                foreach (hist[k]) hist[k] = '0;
                wpos = 0;
            end
            default: begin
                foreach (coef[k]) coef[k] = '0;
                wpos = 0;
            end
        endcase
    endfunction

    // receiver: stalls on its own pattern, checks at rising edge
    int rx_mode;
    initial begin
        out_ch.ready = 1'b0;
        rx_mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            out_seen++;
            if (filter_q.size() == 0)
                report("unexpected word", out_ch.filter_out, 0);
            else begin
                if (out_ch.filter_out !== filter_q[0])
                    report("filter_out", out_ch.filter_out, filter_q[0]);
                void'(filter_q.pop_front());
            end
        end
    end

    int burst_left;

    task automatic send_word(input logic [1:0] a, input logic signed [15:0] s,
                             input logic signed [15:0] e);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid     = 1'b1;
        in_ch.action    = a;
        in_ch.sample_in = s;
        in_ch.error_in  = e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        model_item(a, s, e);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (filter_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [15:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_STEP) mu = val;
        else if (idx == CFG_REG) eps = val;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    t_stim_row dir_tab [$];
    t_stim_row r;
    logic [1:0] act;
    logic [15:0] cfg_set [4][2];

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_FILT;
        in_ch.sample_in = '0;
        in_ch.error_in = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STEP;
        cfg_ch.data = '0;
        errors = 0;
        out_seen = 0;
        burst_left = 0;
        foreach (hist[k]) hist[k] = '0;
        foreach (coef[k]) coef[k] = '0;
        wpos = 0;
        mu = STEP_RESET;
        eps = REG_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows; zero coefficients after reset give zero output
        dir_tab.push_back('{ACT_FILT, 16'sh7FFF, 16'sh0000, 1'b1, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh8000, 16'sh0000, 1'b1, 16'sh0000});
        dir_tab.push_back('{ACT_UPD,  16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_UPD,  16'sh0000, 16'sh8000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh0001, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'shFFFF, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_CLRH, 16'sh1234, 16'sh4321, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_UPD,  16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh4000, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_UPD,  16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_UPD,  16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh7FFF, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh8000, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_CLRC, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000});
        dir_tab.push_back('{ACT_FILT, 16'sh5555, 16'sh0000, 1'b1, 16'sh0000});
        dir_tab.push_back('{ACT_CLRH, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000});
        foreach (dir_tab[n]) begin
            r = dir_tab[n];
            if (r.has_out) begin
                while (filter_q.size() != 0) @(negedge i_clk);
                send_word(r.action, r.sample, r.err);
                if (filter_q.size() != 0 && filter_q[filter_q.size() - 1] !== r.out_val)
                    report("directed row", filter_q[filter_q.size() - 1], r.out_val);
            end else
                send_word(r.action, r.sample, r.err);
        end
        drain();

        // zero regularizer with empty history
        write_cfg(CFG_REG, 16'd0);
        send_word(ACT_UPD, 16'sh0000, 16'sh7FFF);
        send_word(ACT_FILT, 16'sh2000, 16'sh0000);
        drain();

        cfg_set = '{'{16'hFFFF, 16'hFFFF}, '{16'd0, 16'd7}, '{16'd6554, 16'd1},
                    '{16'd300, 16'd0}};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_cfg(CFG_STEP, cfg_set[ph-1][0]);
                write_cfg(CFG_REG, cfg_set[ph-1][1]);
                write_cfg(8'd5, 16'($urandom_range(0, 65535)));
            end
            for (int n = 0; n < 150; n++) begin
                if (n == 75) drain();
                case ($urandom_range(0, 19))
                    0: act = ACT_CLRH;
                    1: act = ACT_CLRC;
                    2, 3, 4, 5, 6: act = ACT_UPD;
                    default: act = ACT_FILT;
                endcase
                send_word(act, rand_sample(), rand_sample());
            end
            drain();
        end

        if (errors == 0 && filter_q.size() == 0)
            $display("** nlms_adaptive_fir: PASSED **");
        else
            $display("** nlms_adaptive_fir: FAILED **");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/nlms_pkg.sv
src/nlms_if.sv
src/nlms_adaptive_fir.sv
sim/tb_top.sv
